### rtl/intok_pkg.sv
// ----------------------------------------------------------------------------
// intok_pkg
// Shared types and constants of the identifier and number tokenizer
// ----------------------------------------------------------------------------
package intok_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int LEN_OUT_W       = 16;
  localparam int VALUE_W         = 31;
  localparam int Q_DEPTH         = 2;
  localparam int Q_AW            = 1;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    CLS_END,
    CLS_SPACE,
    CLS_ALPHA,
    CLS_DIGIT,
    CLS_DOT,
    CLS_UNDER,
    CLS_OTHER
  } char_cls_t;

  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_FILE    = 3'd1,
    KIND_NAME    = 3'd2,
    KIND_NUM     = 3'd3,
    KIND_UNKNOWN = 3'd4
  } tok_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NAME,
    MODE_NUM
  } scan_mode_t;

  typedef struct packed {
    char_cls_t  cls;
    logic [3:0] digit;
  } tok_item_t;

  typedef struct packed {
    tok_kind_t            kind;
    logic [LEN_OUT_W-1:0] length;
    logic [VALUE_W-1:0]   value;
    logic                 last;
  } tok_result_t;

endpackage

### rtl/intok_if.sv
// ----------------------------------------------------------------------------
// intok interfaces
// Byte request channel and token result channel
// ----------------------------------------------------------------------------
interface intok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface intok_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_length;
  logic [30:0] number_value;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_length,
                  output number_value, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_length,
                  input number_value, input last_of_run, output ready);
endinterface

### rtl/identifier_number_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// identifier_number_tokenizer_unit
// Splits a text byte stream into name, file name, number, unknown and end
// tokens
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    in_byte
//   out_chan  out  valid/ready    token_kind, token_length, number_value,
//                                 last_of_run
//
// one byte request per cycle while the queue has room; a result passes the
// queue and the output register; a byte that closes a token and gives a
// second result holds the scanner while it waits in its holding register
// a two-entry queue parts the classifier from the scanner
// reset is synchronous and needs no clearing pass
// ----------------------------------------------------------------------------
module identifier_number_tokenizer_unit #(
  parameter int LENGTH_BITS = intok_pkg::LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  intok_in_if.sink    in_chan,
  intok_out_if.source out_chan
);
  import intok_pkg::*;

  logic        q_ready;
  logic        q_push;
  tok_item_t   q_push_item;
  logic        q_pop;
  logic        q_valid;
  tok_item_t   q_pop_item;
  tok_result_t res;

  intok_front u_front (
    .in_valid (in_chan.valid),
    .in_byte  (in_chan.in_byte),
    .in_ready (in_chan.ready),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  intok_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_pop_item)
  );

  intok_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_pop_item),
    .q_pop     (q_pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  assign out_chan.token_kind   = res.kind;
  assign out_chan.token_length = res.length;
  assign out_chan.number_value = res.value;
  assign out_chan.last_of_run  = res.last;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (res.kind == KIND_END || res.kind == KIND_UNKNOWN))
      |-> (res.last && res.length == LEN_OUT_W'(LENGTH_BITS'(1))))
    else $error("end or unknown token not last or not of length one");

  a_value_only_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && res.kind != KIND_NUM) |-> (res.value == '0))
    else $error("value on a token that is not a number");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("scanner took from an empty queue");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !res.last) |=> out_chan.valid)
    else $error("second result of a byte did not follow its first");
`endif

endmodule

### rtl/intok_front.sv
// ----------------------------------------------------------------------------
// intok_front
// Accepts text bytes and classifies them into character classes
// ----------------------------------------------------------------------------
module intok_front (
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  output logic                 in_ready,
  input  logic                 q_ready,
  output logic                 q_push,
  output intok_pkg::tok_item_t q_item
);
  import intok_pkg::*;

  char_cls_t cls;

  always_comb begin
    if (in_byte == CH_NUL) begin
      cls = CLS_END;
    end else if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                 in_byte == CH_LF || in_byte == CH_CR) begin
      cls = CLS_SPACE;
    end else if ((in_byte >= CH_LA && in_byte <= CH_LZ) ||
                 (in_byte >= CH_UA && in_byte <= CH_UZ)) begin
      cls = CLS_ALPHA;
    end else if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
      cls = CLS_DIGIT;
    end else if (in_byte == CH_DOT) begin
      cls = CLS_DOT;
    end else if (in_byte == CH_UNDER) begin
      cls = CLS_UNDER;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign in_ready     = q_ready;
  assign q_push       = in_valid && q_ready;
  assign q_item.cls   = cls;
  assign q_item.digit = 4'(in_byte - CH_ZERO);

endmodule

### rtl/intok_queue.sv
// ----------------------------------------------------------------------------
// intok_queue
// Short queue of classified requests between front and back
// ----------------------------------------------------------------------------
module intok_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  intok_pkg::tok_item_t push_item,
  output logic                 push_ready,
  input  logic                 pop,
  output logic                 pop_valid,
  output intok_pkg::tok_item_t pop_item
);
  import intok_pkg::*;

  tok_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;

  assign push_ready = (count_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/intok_back.sv
// ----------------------------------------------------------------------------
// intok_back
// Token scanner: runs names and numbers, builds results, output register
// ----------------------------------------------------------------------------
module intok_back #(
  parameter int LENGTH_BITS = intok_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  intok_pkg::tok_item_t   q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output intok_pkg::tok_result_t out_res
);
  import intok_pkg::*;

  localparam int PW = VALUE_W + 4;

  scan_mode_t             mode_r, mode_nxt;
  logic                   dot_r, dot_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [VALUE_W-1:0]     val_r, val_nxt;
  logic                   out_valid_r, out_valid_nxt;
  tok_result_t            out_r, out_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  tok_result_t            pend_r, pend_nxt;

  logic                   slot_free;
  logic                   cont;
  logic                   flush;
  logic                   idle_res;
  tok_result_t            flush_tok;
  tok_result_t            idle_tok;
  tok_result_t            first_tok;
  logic [PW-1:0]          prod;
  logic [LENGTH_BITS-1:0] len_inc;

  assign slot_free = !out_valid_r || out_ready;
  assign q_pop     = q_valid && !pend_valid_r && slot_free;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  assign prod    = PW'({val_r, 3'b000}) + PW'({val_r, 1'b0}) + PW'(q_item.digit);
  assign len_inc = (len_r == '1) ? len_r : len_r + 1'b1;

  always_comb begin
    cont = 1'b0;
    case (mode_r)
      MODE_NAME: cont = (q_item.cls == CLS_ALPHA) || (q_item.cls == CLS_DIGIT) ||
                        (q_item.cls == CLS_DOT) || (q_item.cls == CLS_UNDER);
      MODE_NUM:  cont = (q_item.cls == CLS_DIGIT);
      default:   cont = 1'b0;
    endcase
  end

  assign flush = ((mode_r == MODE_NAME) || (mode_r == MODE_NUM)) && !cont;

  // pending token closed by this request
  always_comb begin
    flush_tok.kind   = (mode_r == MODE_NUM) ? KIND_NUM : (dot_r ? KIND_FILE : KIND_NAME);
    flush_tok.length = LEN_OUT_W'(len_r);
    flush_tok.value  = (mode_r == MODE_NUM) ? val_r : '0;
    flush_tok.last   = 1'b0;
  end

  // result of the request taken from idle
  always_comb begin
    idle_res        = 1'b0;
    idle_tok.kind   = KIND_UNKNOWN;
    idle_tok.length = LEN_OUT_W'(LENGTH_BITS'(1));
    idle_tok.value  = '0;
    idle_tok.last   = 1'b1;
    case (q_item.cls)
      CLS_END: begin
        idle_res      = 1'b1;
        idle_tok.kind = KIND_END;
      end
      CLS_SPACE, CLS_ALPHA, CLS_DIGIT: idle_res = 1'b0;
      default: idle_res = 1'b1;
    endcase
  end

  always_comb begin
    first_tok      = flush ? flush_tok : idle_tok;
    first_tok.last = !(flush && idle_res);
  end

  always_comb begin
    mode_nxt       = mode_r;
    dot_nxt        = dot_r;
    len_nxt        = len_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;

    if (pend_valid_r && slot_free) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = pend_r;
      pend_valid_nxt = 1'b0;
    end

    if (q_pop) begin
      if (cont) begin
        len_nxt = len_inc;
        if (q_item.cls == CLS_DOT) begin
          dot_nxt = 1'b1;
        end
        if (mode_r == MODE_NUM) begin
          val_nxt = (prod > PW'(VALUE_MAX)) ? VALUE_MAX : prod[VALUE_W-1:0];
        end
      end else begin
        mode_nxt = MODE_IDLE;
        case (q_item.cls)
          CLS_ALPHA: begin
            mode_nxt = MODE_NAME;
            dot_nxt  = 1'b0;
            len_nxt  = LENGTH_BITS'(1);
            val_nxt  = '0;
          end
          CLS_DIGIT: begin
            mode_nxt = MODE_NUM;
            dot_nxt  = 1'b0;
            len_nxt  = LENGTH_BITS'(1);
            val_nxt  = VALUE_W'(q_item.digit);
          end
          default: mode_nxt = MODE_IDLE;
        endcase
        if (flush || idle_res) begin
          out_valid_nxt = 1'b1;
          out_nxt       = first_tok;
        end
        if (flush && idle_res) begin
          pend_valid_nxt = 1'b1;
          pend_nxt       = idle_tok;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      dot_r        <= 1'b0;
      len_r        <= '0;
      val_r        <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      dot_r        <= dot_nxt;
      len_r        <= len_nxt;
      val_r        <= val_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

endmodule
